FILE: sv/rmst_pkg.sv
package rmst_pkg;

  // default element count of the tree
  localparam int unsigned SizeDefault = 1024;

  // field widths
  localparam int unsigned CfgW   = 11;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned DataW  = 32;
  localparam int unsigned PaddrW = 3;

  // register index taken from paddr above the byte offset
  localparam logic RegActiveSize = 1'b0;

  // request opcodes
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // engine sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WDESC,
    ST_WLEAF,
    ST_WREAD,
    ST_WUP,
    ST_QVISIT,
    ST_QDRAIN,
    ST_DONE
  } state_e;

endpackage

FILE: sv/range_max_segment_tree_core.sv
// channel   direction  handshake                payload
// --------  ---------  -----------------------  ---------------------------------
// request   in         in_valid_i / in_stall_o  cmd_i, index_i, high_index_i, value_i
// result    out        out_valid_o / out_stall_i  max_value_o, ok_o
// config    in         apb psel/penable/pready  paddr, pwdata, prdata
//
// one request at a time, sequenced over a single-port tree store
// write: walk down to the leaf, write it, then per level up read the sibling and write the parent, then hand off
// query: one intersecting node per cycle, then a drain step and the hand-off
// rejected requests and empty ranges go straight to the hand-off
// after reset all 2*SIZE store entries are cleared at one entry a cycle, requests stalled
// a finished result waits in the output register while the next request is taken
module range_max_segment_tree_core #(
  parameter int unsigned SIZE = rmst_pkg::SizeDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmst_pkg::PaddrW-1:0] paddr,
  input  logic [rmst_pkg::DataW-1:0]  pwdata,
  output logic [rmst_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  // request
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [rmst_pkg::IdxW-1:0]   index_i,
  input  logic [rmst_pkg::IdxW-1:0]   high_index_i,
  input  logic [rmst_pkg::DataW-1:0]  value_i,
  // result
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rmst_pkg::DataW-1:0]  max_value_o,
  output logic                        ok_o
);

  localparam int unsigned Depth = 2 * SIZE;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned SizeW = $clog2(SIZE + 1);
  localparam int unsigned ActW  = (rmst_pkg::CfgW > SizeW) ? rmst_pkg::CfgW : SizeW;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  logic [ActW-1:0]            n;
  logic                       mem_en, mem_we;
  logic [AddrW-1:0]           mem_addr;
  logic [rmst_pkg::DataW-1:0] mem_wdata, mem_rdata;

  rmst_cfg #(
    .SIZE (SIZE),
    .ActW (ActW)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .n_o     (n)
  );

  rmst_engine #(
    .SIZE  (SIZE),
    .AddrW (AddrW),
    .ActW  (ActW)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_i          (n),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .index_i      (index_i),
    .high_index_i (high_index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .max_value_o  (max_value_o),
    .ok_o         (ok_o),
    .mem_en_o     (mem_en),
    .mem_we_o     (mem_we),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .mem_rdata_i  (mem_rdata)
  );

  rmst_ram #(
    .Depth (Depth),
    .AddrW (AddrW),
    .DataW (rmst_pkg::DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

`ifndef SYNTHESIS
  // store accesses stay inside the tree store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_en |-> (mem_addr <= LastAddr))
    else $error("tree store access beyond its depth");

  // a taken request keeps the engine busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("engine idle right after taking a request");

  // a new result only comes out of a request in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");
`endif

endmodule

FILE: sv/rmst_ram.sv
module rmst_ram #(
  parameter int unsigned Depth = 2 * rmst_pkg::SizeDefault,
  parameter int unsigned AddrW = $clog2(2 * rmst_pkg::SizeDefault),
  parameter int unsigned DataW = rmst_pkg::DataW
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

FILE: sv/rmst_cfg.sv
module rmst_cfg #(
  parameter int unsigned SIZE = rmst_pkg::SizeDefault,
  parameter int unsigned ActW = rmst_pkg::CfgW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmst_pkg::PaddrW-1:0] paddr,
  input  logic [rmst_pkg::DataW-1:0]  pwdata,
  output logic [rmst_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output logic [ActW-1:0]             n_o
);

  localparam logic [ActW-1:0] SizeVal = ActW'(SIZE);

  logic [ActW-1:0] active_q, active_d;
  logic            sel_active;

  assign sel_active = (paddr[rmst_pkg::PaddrW-1] == rmst_pkg::RegActiveSize);
  assign pready     = 1'b1;

  // register write on the access cycle
  always_comb begin
    active_d = active_q;
    if (psel && penable && pwrite && pready && sel_active) begin
      active_d = ActW'(pwdata[rmst_pkg::CfgW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= SizeVal;
    end else begin
      active_q <= active_d;
    end
  end

  // readback
  assign prdata = sel_active ? rmst_pkg::DataW'(active_q) : '0;

  // effective size, clamped to the store
  assign n_o = (active_q > SizeVal) ? SizeVal : active_q;

endmodule

FILE: sv/rmst_engine.sv
module rmst_engine #(
  parameter int unsigned SIZE  = rmst_pkg::SizeDefault,
  parameter int unsigned AddrW = $clog2(2 * rmst_pkg::SizeDefault),
  parameter int unsigned ActW  = rmst_pkg::CfgW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ActW-1:0]            n_i,
  // request side
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       cmd_i,
  input  logic [rmst_pkg::IdxW-1:0]  index_i,
  input  logic [rmst_pkg::IdxW-1:0]  high_index_i,
  input  logic [rmst_pkg::DataW-1:0] value_i,
  // result side
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [rmst_pkg::DataW-1:0] max_value_o,
  output logic                       ok_o,
  // tree store port
  output logic                       mem_en_o,
  output logic                       mem_we_o,
  output logic [AddrW-1:0]           mem_addr_o,
  output logic [rmst_pkg::DataW-1:0] mem_wdata_o,
  input  logic [rmst_pkg::DataW-1:0] mem_rdata_i
);

  localparam int unsigned DW       = rmst_pkg::DataW;
  localparam int unsigned StkDepth = $clog2(SIZE) + 1;
  localparam int unsigned StkAw    = $clog2(StkDepth);
  localparam int unsigned StkPw    = $clog2(StkDepth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(2 * SIZE - 1);
  localparam logic [AddrW-1:0] RootNode = AddrW'(1);

  rmst_pkg::state_e state_q, state_d;

  logic [ActW-1:0]  ql_q, ql_d, qr_q, qr_d;
  logic [ActW-1:0]  l_q, l_d, r_q, r_d;
  logic [AddrW-1:0] node_q, node_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [DW-1:0]    val_q, val_d;
  logic [DW-1:0]    acc_q, acc_d;
  logic [DW-1:0]    cur_q, cur_d;
  logic             ok_q, ok_d;
  logic             rd_pend_q, rd_pend_d;
  logic             sib_ok_q, sib_ok_d;
  logic [StkPw-1:0] sp_q, sp_d;

  // pending right halves of the query walk
  logic [ActW-1:0]  stk_l_q    [StkDepth];
  logic [ActW-1:0]  stk_r_q    [StkDepth];
  logic [AddrW-1:0] stk_node_q [StkDepth];

  logic             out_valid_q, out_valid_d;
  logic [DW-1:0]    out_max_q;
  logic             out_ok_q;
  logic             out_load;

  logic [ActW:0]    sum;
  logic [ActW-1:0]  mid, mid_p1;
  logic [AddrW-1:0] node_lo, node_hi, sib, parent;
  logic             node_in, sib_in, parent_in;
  logic [DW-1:0]    sib_val, par_val;
  logic [StkPw-1:0] sp_m1;
  logic [StkAw-1:0] top_idx, push_idx;
  logic             push, pop;
  logic             full, lhit, rhit;
  logic [ActW-1:0]  lo_x, hi_x;
  logic             lo_ok, hi_ok;

  // shared datapath terms
  assign sum      = {1'b0, l_q} + {1'b0, r_q};
  assign mid      = sum[ActW:1];
  assign mid_p1   = mid + ActW'(1);
  assign node_lo  = {node_q[AddrW-2:0], 1'b0};
  assign node_hi  = {node_q[AddrW-2:0], 1'b1};
  assign sib      = node_q ^ RootNode;
  assign parent   = {1'b0, node_q[AddrW-1:1]};
  assign node_in  = (node_q <= LastAddr);
  assign sib_in   = (sib <= LastAddr);
  assign parent_in = (parent <= LastAddr);
  assign sib_val  = sib_ok_q ? mem_rdata_i : '0;
  assign par_val  = (cur_q > sib_val) ? cur_q : sib_val;
  assign sp_m1    = sp_q - StkPw'(1);
  assign top_idx  = sp_m1[StkAw-1:0];
  assign push_idx = sp_q[StkAw-1:0];
  assign full     = (ql_q <= l_q) && (r_q <= qr_q);
  assign lhit     = (ql_q <= mid);
  assign rhit     = (qr_q >= mid_p1);
  assign lo_x     = ActW'(index_i);
  assign hi_x     = ActW'(high_index_i);
  assign lo_ok    = (lo_x < n_i);
  assign hi_ok    = (hi_x < n_i);

  assign in_stall_o = (state_q != rmst_pkg::ST_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    ql_d        = ql_q;
    qr_d        = qr_q;
    l_d         = l_q;
    r_d         = r_q;
    node_d      = node_q;
    clr_d       = clr_q;
    val_d       = val_q;
    cur_d       = cur_q;
    ok_d        = ok_q;
    sib_ok_d    = sib_ok_q;
    sp_d        = sp_q;
    rd_pend_d   = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    out_load    = 1'b0;
    mem_en_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = node_q;
    mem_wdata_o = '0;

    // fold in the node read issued last cycle
    acc_d = acc_q;
    if (rd_pend_q && (mem_rdata_i > acc_q)) begin
      acc_d = mem_rdata_i;
    end

    case (state_q)
      rmst_pkg::ST_CLEAR: begin
        mem_en_o   = 1'b1;
        mem_we_o   = 1'b1;
        mem_addr_o = clr_q;
        clr_d      = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          state_d = rmst_pkg::ST_IDLE;
        end
      end

      rmst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ql_d   = lo_x;
          qr_d   = hi_x;
          val_d  = value_i;
          acc_d  = '0;
          l_d    = '0;
          r_d    = n_i - ActW'(1);
          node_d = RootNode;
          sp_d   = '0;
          if (cmd_i == rmst_pkg::CmdWrite) begin
            ok_d    = lo_ok;
            state_d = lo_ok ? rmst_pkg::ST_WDESC : rmst_pkg::ST_DONE;
          end else begin
            ok_d = lo_ok && hi_ok;
            if (lo_ok && hi_ok && (hi_x >= lo_x)) begin
              state_d = rmst_pkg::ST_QVISIT;
            end else begin
              state_d = rmst_pkg::ST_DONE;
            end
          end
        end
      end

      // walk down to the leaf of the written element
      rmst_pkg::ST_WDESC: begin
        if (l_q < r_q) begin
          if (ql_q <= mid) begin
            r_d    = mid;
            node_d = node_lo;
          end else begin
            l_d    = mid_p1;
            node_d = node_hi;
          end
        end else begin
          state_d = rmst_pkg::ST_WLEAF;
        end
      end

      rmst_pkg::ST_WLEAF: begin
        mem_en_o    = node_in;
        mem_we_o    = 1'b1;
        mem_wdata_o = val_q;
        cur_d       = node_in ? val_q : '0;
        state_d     = (node_q == RootNode) ? rmst_pkg::ST_DONE : rmst_pkg::ST_WREAD;
      end

      rmst_pkg::ST_WREAD: begin
        mem_en_o   = sib_in;
        mem_addr_o = sib;
        sib_ok_d   = sib_in;
        state_d    = rmst_pkg::ST_WUP;
      end

      // parent takes the larger child
      rmst_pkg::ST_WUP: begin
        mem_en_o    = parent_in;
        mem_we_o    = 1'b1;
        mem_addr_o  = parent;
        mem_wdata_o = par_val;
        cur_d       = par_val;
        node_d      = parent;
        state_d     = (parent == RootNode) ? rmst_pkg::ST_DONE : rmst_pkg::ST_WREAD;
      end

      // one intersecting node per cycle
      rmst_pkg::ST_QVISIT: begin
        if (full) begin
          mem_en_o  = node_in;
          rd_pend_d = node_in;
          pop       = 1'b1;
        end else if (!node_in) begin
          pop = 1'b1;
        end else if (lhit) begin
          push   = rhit;
          r_d    = mid;
          node_d = node_lo;
        end else begin
          l_d    = mid_p1;
          node_d = node_hi;
        end
        if (push) begin
          sp_d = sp_q + StkPw'(1);
        end
        if (pop) begin
          if (sp_q == '0) begin
            state_d = rmst_pkg::ST_QDRAIN;
          end else begin
            l_d    = stk_l_q[top_idx];
            r_d    = stk_r_q[top_idx];
            node_d = stk_node_q[top_idx];
            sp_d   = sp_m1;
          end
        end
      end

      rmst_pkg::ST_QDRAIN: begin
        state_d = rmst_pkg::ST_DONE;
      end

      rmst_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = rmst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rmst_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmst_pkg::ST_CLEAR;
      clr_q       <= '0;
      sp_q        <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ql_q     <= ql_d;
    qr_q     <= qr_d;
    l_q      <= l_d;
    r_q      <= r_d;
    node_q   <= node_d;
    val_q    <= val_d;
    acc_q    <= acc_d;
    cur_q    <= cur_d;
    ok_q     <= ok_d;
    sib_ok_q <= sib_ok_d;
    if (push) begin
      stk_l_q[push_idx]    <= mid_p1;
      stk_r_q[push_idx]    <= r_q;
      stk_node_q[push_idx] <= node_hi;
    end
    if (out_load) begin
      out_max_q <= acc_q;
      out_ok_q  <= ok_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_value_o = out_max_q;
  assign ok_o        = out_ok_q;

endmodule

FILE: test/range_max_segment_tree_core_test.sv
`timescale 1ns / 1ps

module range_max_segment_tree_core_test;

  localparam int unsigned PhaseCount     = 10;
  localparam int unsigned RandomPerPhase = 83;
  localparam int unsigned DrainCycles    = 64;
  localparam int unsigned HoldCycles     = 300;
  localparam int unsigned TreeDepth      = 2 * rmst_pkg::SizeDefault;

  // active_size setting per phase, extremes included
  localparam logic [rmst_pkg::CfgW-1:0] SizePlan [PhaseCount] = '{
    11'd1024, 11'd1, 11'd2, 11'd1000, 11'd2047, 11'd0, 11'd37, 11'd1500, 11'd513, 11'd1024
  };

  typedef struct packed {
    logic [rmst_pkg::DataW-1:0] max_value;
    logic                       ok;
  } tree_result_t;

  // predicts results of the tree and checks them in order
  class tree_scoreboard;
    logic [rmst_pkg::DataW-1:0] nodes [TreeDepth];
    logic [rmst_pkg::CfgW-1:0]  size_reg;
    tree_result_t               pending [$];
    int unsigned                errors, writes, queries, rejected, checked;

    function new();
      foreach (nodes[i]) nodes[i] = '0;
      size_reg = rmst_pkg::CfgW'(rmst_pkg::SizeDefault);
    endfunction

    function void set_size(input logic [rmst_pkg::CfgW-1:0] s);
      size_reg = s;
    endfunction

    // sizes above the array length act as the full array
    function int unsigned span();
      return (size_reg > rmst_pkg::SizeDefault) ? rmst_pkg::SizeDefault : int'(size_reg);
    endfunction

    function logic [rmst_pkg::DataW-1:0] node_rd(input int unsigned nd);
      return (nd < TreeDepth) ? nodes[nd] : '0;
    endfunction

    function void node_wr(input int unsigned nd, input logic [rmst_pkg::DataW-1:0] v);
      if (nd < TreeDepth) nodes[nd] = v;
    endfunction

    function logic [rmst_pkg::DataW-1:0] span_max(input int unsigned ql, qr, l, r, nd);
      int unsigned                m;
      logic [rmst_pkg::DataW-1:0] a, b;
      if (r < ql || qr < l) return '0;
      if (ql <= l && r <= qr) return node_rd(nd);
      if (nd >= TreeDepth) return '0;
      m = (l + r) / 2;
      a = span_max(ql, qr, l, m, 2 * nd);
      b = span_max(ql, qr, m + 1, r, 2 * nd + 1);
      return (a > b) ? a : b;
    endfunction

    // set the leaf, then rebuild each parent from both children
    function void load_element(input int unsigned k, input logic [rmst_pkg::DataW-1:0] v,
                               input int unsigned l, r, nd);
      int unsigned                m;
      logic [rmst_pkg::DataW-1:0] a, b;
      if (l >= r) begin
        node_wr(nd, v);
        return;
      end
      m = (l + r) / 2;
      if (k <= m) load_element(k, v, l, m, 2 * nd);
      else load_element(k, v, m + 1, r, 2 * nd + 1);
      a = node_rd(2 * nd);
      b = node_rd(2 * nd + 1);
      node_wr(nd, (a > b) ? a : b);
    endfunction

    function void note_request(input logic c, input logic [rmst_pkg::IdxW-1:0] lo, hi,
                               input logic [rmst_pkg::DataW-1:0] v);
      int unsigned  n;
      tree_result_t r;
      n = span();
      r = '0;
      if (c == rmst_pkg::CmdWrite) begin
        writes++;
        if (lo < n) begin
          load_element(lo, v, 0, n - 1, 1);
          r.ok = 1'b1;
        end
      end else begin
        queries++;
        if (lo < n && hi < n) begin
          r.ok = 1'b1;
          if (hi >= lo) r.max_value = span_max(lo, hi, 0, n - 1, 1);
        end
      end
      if (!r.ok) rejected++;
      pending.push_back(r);
    endfunction

    function void check_result(input logic [rmst_pkg::DataW-1:0] mx, input logic ok);
      tree_result_t r;
      if (pending.size() == 0) begin
        $error("unexpected result: max_value %0h ok %0b", mx, ok);
        errors++;
        return;
      end
      r = pending.pop_front();
      checked++;
      if (mx !== r.max_value) begin
        $error("max_value mismatch: expected %0h, got %0h", r.max_value, mx);
        errors++;
      end
      if (ok !== r.ok) begin
        $error("ok mismatch: expected %0b, got %0b", r.ok, ok);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        psel         = 1'b0;
  logic                        penable      = 1'b0;
  logic                        pwrite       = 1'b0;
  logic [rmst_pkg::PaddrW-1:0] paddr        = '0;
  logic [rmst_pkg::DataW-1:0]  pwdata       = '0;
  logic [rmst_pkg::DataW-1:0]  prdata;
  logic                        pready;
  logic                        in_valid_i   = 1'b0;
  logic                        in_stall_o;
  logic                        cmd_i        = rmst_pkg::CmdWrite;
  logic [rmst_pkg::IdxW-1:0]   index_i      = '0;
  logic [rmst_pkg::IdxW-1:0]   high_index_i = '0;
  logic [rmst_pkg::DataW-1:0]  value_i      = '0;
  logic                        out_valid_o;
  logic                        out_stall_i  = 1'b0;
  logic [rmst_pkg::DataW-1:0]  max_value_o;
  logic                        ok_o;

  tree_scoreboard tree_sb = new();
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  bit             hold_off_req   = 1'b0;

  range_max_segment_tree_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .index_i      (index_i),
    .high_index_i (high_index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .max_value_o  (max_value_o),
    .ok_o         (ok_o)
  );

  always #6 clk_i = ~clk_i;

  // watchdog
  initial begin
    #5_000_000;
    $display("range_max_segment_tree_core_test: done, errors");
    $finish;
  end

  // result side: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tree_sb.check_result(max_value_o, ok_o);
  end

  // one request, with optional idle cycles ahead of it
  task automatic send_request(input logic c, input logic [rmst_pkg::IdxW-1:0] lo, hi,
                              input logic [rmst_pkg::DataW-1:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= c;
    index_i      <= lo;
    high_index_i <= hi;
    value_i      <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tree_sb.note_request(c, lo, hi, v);
  endtask

  // mostly in-range indices, some out of range, some empty ranges
  task automatic send_random_request();
    int unsigned                n, pick, t;
    logic                       c;
    logic [rmst_pkg::IdxW-1:0]  lo, hi;
    logic [rmst_pkg::DataW-1:0] v;
    n  = tree_sb.span();
    c  = ($urandom_range(99) < 45) ? rmst_pkg::CmdWrite : rmst_pkg::CmdQuery;
    lo = rmst_pkg::IdxW'($urandom);
    hi = rmst_pkg::IdxW'($urandom);
    v  = $urandom;
    if (n != 0 && $urandom_range(99) >= 12) lo = rmst_pkg::IdxW'($urandom_range(n - 1));
    if (n != 0) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        t  = lo + $urandom_range(($urandom_range(3) == 0) ? n : 16);
        hi = rmst_pkg::IdxW'((t > n - 1) ? n - 1 : t);
      end else if (pick < 75) begin
        hi = rmst_pkg::IdxW'($urandom_range(n - 1));
      end else if (pick < 88 && lo != 0) begin
        hi = rmst_pkg::IdxW'($urandom_range(lo - 1));
      end
    end
    pick = $urandom_range(9);
    if (pick < 3) v = $urandom_range(255);
    else if (pick == 3) v = '1;
    send_request(c, lo, hi, v);
  endtask

  task automatic write_active_size(input logic [rmst_pkg::CfgW-1:0] s);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {rmst_pkg::RegActiveSize, 2'b00};
    pwdata  <= rmst_pkg::DataW'(s);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tree_sb.set_size(s);
  endtask

  // let every outstanding result come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tree_sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned ph);
    case (ph % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 69;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 69;
      end
      default: begin
        send_idle_pct  = 16;
        recv_stall_pct = 16;
      end
    endcase
  endtask

  // full-size array: extremes, lowering a maximum, empty ranges, ignored fields
  task automatic run_directed();
    send_request(rmst_pkg::CmdQuery, 10'd0, 10'd1023, 32'h0);
    send_request(rmst_pkg::CmdWrite, 10'd0, 10'd0, 32'hFFFF_FFFF);
    send_request(rmst_pkg::CmdWrite, 10'd1023, 10'd0, 32'h8000_0000);
    send_request(rmst_pkg::CmdWrite, 10'd512, 10'd0, 32'h1);
    send_request(rmst_pkg::CmdWrite, 10'd511, 10'd0, 32'h7FFF_FFFF);
    send_request(rmst_pkg::CmdQuery, 10'd0, 10'd1023, 32'h0);
    send_request(rmst_pkg::CmdQuery, 10'd1, 10'd1023, 32'h0);
    send_request(rmst_pkg::CmdQuery, 10'd1023, 10'd1023, 32'h0);
    send_request(rmst_pkg::CmdQuery, 10'd512, 10'd1022, 32'h0);
    send_request(rmst_pkg::CmdQuery, 10'd0, 10'd0, 32'h0);
    send_request(rmst_pkg::CmdQuery, 10'd10, 10'd5, 32'h0);
    send_request(rmst_pkg::CmdQuery, 10'd1023, 10'd0, 32'h0);
    send_request(rmst_pkg::CmdWrite, 10'd0, 10'd0, 32'h0);
    send_request(rmst_pkg::CmdQuery, 10'd0, 10'd1023, 32'h0);
    send_request(rmst_pkg::CmdQuery, 10'd0, 10'd511, 32'h0);
    send_request(rmst_pkg::CmdWrite, 10'd1023, 10'd0, 32'h5555_AAAA);
    send_request(rmst_pkg::CmdQuery, 10'd300, 10'd700, 32'hDEAD_BEEF);
    send_request(rmst_pkg::CmdWrite, 10'd700, 10'd1023, 32'h2);
    send_request(rmst_pkg::CmdQuery, 10'd600, 10'd1023, 32'h0);
  endtask

  // small array: indices at and past the end
  task automatic run_bounds_checks();
    send_request(rmst_pkg::CmdWrite, 10'd37, 10'd0, 32'h1234_5678);
    send_request(rmst_pkg::CmdQuery, 10'd0, 10'd37, 32'h0);
    send_request(rmst_pkg::CmdQuery, 10'd37, 10'd36, 32'h0);
    send_request(rmst_pkg::CmdWrite, 10'd36, 10'd0, 32'hFFFF_FFFF);
    send_request(rmst_pkg::CmdQuery, 10'd36, 10'd36, 32'h0);
    send_request(rmst_pkg::CmdQuery, 10'd0, 10'd36, 32'h0);
  endtask

  // main sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(0);
    run_directed();
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      if (ph != 0) begin
        drain_results();
        write_active_size(SizePlan[ph]);
      end
      set_idling(ph);
      if (SizePlan[ph] == 11'd37) run_bounds_checks();
      for (int unsigned i = 0; i < RandomPerPhase; i++) begin
        if (ph == 4 && i == 20) hold_off_req = 1'b1;
        send_random_request();
      end
    end
    drain_results();
    $display("covered %0d requests: %0d writes, %0d queries, %0d rejected, %0d results checked",
             tree_sb.writes + tree_sb.queries, tree_sb.writes, tree_sb.queries,
             tree_sb.rejected, tree_sb.checked);
    $display("over %0d active_size settings from 0 to 2047, with idle, stall and hold-off phases",
             PhaseCount);
    if (tree_sb.errors == 0) begin
      $display("range_max_segment_tree_core_test: done, clean");
    end else begin
      $display("range_max_segment_tree_core_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rmst_pkg.sv
sv/rmst_ram.sv
sv/rmst_cfg.sv
sv/rmst_engine.sv
sv/range_max_segment_tree_core.sv
test/range_max_segment_tree_core_test.sv
